[sv/bmc_pkg.sv]
// Package for the band mask centroid block: field widths, limits, register
// indexes and the payload types shared by the channels and the submodules.
// Depends on nothing.
`default_nettype none

package bmc_pkg;

  localparam int ColW      = 9;
  localparam int WinW      = 10;
  localparam int RowSumW   = 17;
  localparam int RowCntW   = 10;
  localparam int BandSumW  = 13;
  localparam int BandCntW  = 5;
  localparam int CfgIdxW   = 4;
  localparam int ColCmpW   = 13;

  localparam int MaxCols     = 512;
  localparam int MaxBandRows = 16;

  localparam logic [RowCntW-1:0] RowCntCap =
      RowCntW'((MaxCols > 1023) ? 1023 : MaxCols);
  localparam logic [BandCntW-1:0] BandCntCap =
      BandCntW'((MaxBandRows > 31) ? 31 : MaxBandRows);
  localparam int BandSumMax = 8191;

  localparam logic [WinW-1:0] WindowStartReset = 10'd0;
  localparam logic [WinW-1:0] WindowEndReset   = 10'd512;

  localparam logic [CfgIdxW-1:0] CfgWindowStart = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowEnd   = 4'd1;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;

  localparam int DivCntW = 5;

  typedef struct packed {
    logic            pixel_on;
    logic [ColW-1:0] column;
    logic            row_last;
    logic            band_last;
  } pixel_t;

  typedef struct packed {
    logic            found;
    logic [ColW-1:0] line_x;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [WinW-1:0]    value;
  } cfg_t;

  typedef struct packed {
    logic [RowSumW-1:0] sum;
    logic [RowCntW-1:0] cnt;
    logic               band_last;
  } row_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

[sv/bmc_stream_if.sv]
// Valid/ready channel interface carrying one payload of a chosen type.
// Used for the pixel, result and configuration channels; no dependencies.
`default_nettype none

interface bmc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/bmc_fifo.sv]
// Short queue of closed-row records between the front and the back part.
// Depends on bmc_pkg.
`default_nettype none

module bmc_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bmc_pkg::row_rec_t push_data_i,
  input  wire logic              pop_i,
  output bmc_pkg::row_rec_t      pop_data_o,
  output bmc_pkg::fifo_stat_t    stat_o
);

  bmc_pkg::row_rec_t entries_q [bmc_pkg::FifoDepth];
  logic [bmc_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [bmc_pkg::FifoPtrW:0]   count_q;

  assign stat_o.full  = (count_q == (bmc_pkg::FifoPtrW+1)'(bmc_pkg::FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/bmc_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the row and band
// means. Depends on bmc_pkg.
`default_nettype none

module bmc_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [bmc_pkg::RowSumW-1:0]   dividend_i,
  input  wire logic [bmc_pkg::RowCntW-1:0]   divisor_i,
  output logic                               done_o,
  output logic      [bmc_pkg::RowSumW-1:0]   quotient_o
);

  logic                            busy_q, done_q;
  logic [bmc_pkg::DivCntW-1:0]     cnt_q;
  logic [bmc_pkg::RowSumW-1:0]     quo_q;
  logic [bmc_pkg::RowCntW-1:0]     rem_q, dvs_q;
  logic [bmc_pkg::RowCntW:0]       rem_sh;
  logic                            ge;
  logic [bmc_pkg::RowCntW:0]       rem_diff;

  assign rem_sh   = {rem_q, quo_q[bmc_pkg::RowSumW-1]};
  assign ge       = (rem_sh >= {1'b0, dvs_q});
  assign rem_diff = rem_sh - {1'b0, dvs_q};

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= bmc_pkg::DivCntW'(bmc_pkg::RowSumW);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q <= {quo_q[bmc_pkg::RowSumW-2:0], ge};
        rem_q <= ge ? rem_diff[bmc_pkg::RowCntW-1:0] : rem_sh[bmc_pkg::RowCntW-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == bmc_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/bmc_front.sv]
// Front part: holds the column window registers, filters pixels and sums the
// columns of each row; closed rows go to the queue. Depends on bmc_pkg.
`default_nettype none

module bmc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  bmc_stream_if.sink            pix,
  bmc_stream_if.sink            cfg,
  input  wire bmc_pkg::fifo_stat_t fifo_stat_i,
  output logic                  push_o,
  output bmc_pkg::row_rec_t     push_data_o
);

  logic [bmc_pkg::WinW-1:0]    win_start_q, win_end_q;
  logic [bmc_pkg::RowSumW-1:0] row_sum_q, row_sum_d;
  logic [bmc_pkg::RowCntW-1:0] row_cnt_q, row_cnt_d;
  logic                        accept, hit, take, close;
  logic [bmc_pkg::RowSumW:0]   sum_ext;
  logic [bmc_pkg::WinW-1:0]    col_ext;

  assign pix.ready = !fifo_stat_i.full;
  assign cfg.ready = 1'b1;
  assign accept    = pix.valid && pix.ready;

  assign col_ext = {1'b0, pix.data.column};
  assign hit = pix.data.pixel_on && (col_ext >= win_start_q) && (col_ext < win_end_q) &&
               (bmc_pkg::ColCmpW'(pix.data.column) < bmc_pkg::ColCmpW'(bmc_pkg::MaxCols));
  assign sum_ext = {1'b0, row_sum_q} + (bmc_pkg::RowSumW+1)'(pix.data.column);
  assign take    = hit && (row_cnt_q < bmc_pkg::RowCntCap) && !sum_ext[bmc_pkg::RowSumW];
  assign close   = pix.data.row_last || pix.data.band_last;

  assign row_sum_d = take ? sum_ext[bmc_pkg::RowSumW-1:0] : row_sum_q;
  assign row_cnt_d = take ? (row_cnt_q + 1'b1) : row_cnt_q;

  assign push_o                = accept && close;
  assign push_data_o.sum       = row_sum_d;
  assign push_data_o.cnt       = row_cnt_d;
  assign push_data_o.band_last = pix.data.band_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= bmc_pkg::WindowStartReset;
      win_end_q   <= bmc_pkg::WindowEndReset;
      row_sum_q   <= '0;
      row_cnt_q   <= '0;
    end else begin
      if (cfg.valid) begin
        if (cfg.data.index == bmc_pkg::CfgWindowStart) begin
          win_start_q <= cfg.data.value;
        end else if (cfg.data.index == bmc_pkg::CfgWindowEnd) begin
          win_end_q <= cfg.data.value;
        end
      end
      if (accept) begin
        if (close) begin
          row_sum_q <= '0;
          row_cnt_q <= '0;
        end else begin
          row_sum_q <= row_sum_d;
          row_cnt_q <= row_cnt_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/bmc_back.sv]
// Back part: takes closed rows from the queue, divides them into row means,
// sums the means of the band and emits the band mean through an output
// register. Depends on bmc_pkg and bmc_div.
`default_nettype none

module bmc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bmc_pkg::fifo_stat_t fifo_stat_i,
  input  wire bmc_pkg::row_rec_t   fifo_data_i,
  output logic                     pop_o,
  bmc_stream_if.source             res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_DIV,
    S_ROW_ADD,
    S_BAND_DIV,
    S_EMIT
  } state_e;

  state_e                       state_q, state_d;
  bmc_pkg::row_rec_t            rec_q, rec_d;
  logic [bmc_pkg::BandSumW-1:0] band_sum_q, band_sum_d, nxt_sum;
  logic [bmc_pkg::BandCntW-1:0] band_cnt_q, band_cnt_d, nxt_cnt;
  logic                         found_q, found_d;
  logic [bmc_pkg::ColW-1:0]     line_q, line_d;
  logic                         out_valid_q, out_valid_d;
  bmc_pkg::result_t             out_data_q, out_data_d;
  logic                         div_start, div_done;
  logic [bmc_pkg::RowSumW-1:0]  div_dividend, div_quo;
  logic [bmc_pkg::RowCntW-1:0]  div_divisor;
  logic [bmc_pkg::RowSumW:0]    sum_ext;
  logic                         add_ok;

  bmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign sum_ext = (bmc_pkg::RowSumW+1)'(band_sum_q) + {1'b0, div_quo};
  assign add_ok  = (rec_q.cnt != '0) && (band_cnt_q < bmc_pkg::BandCntCap) &&
                   (sum_ext <= (bmc_pkg::RowSumW+1)'(bmc_pkg::BandSumMax));
  assign nxt_sum = add_ok ? sum_ext[bmc_pkg::BandSumW-1:0] : band_sum_q;
  assign nxt_cnt = add_ok ? (band_cnt_q + 1'b1) : band_cnt_q;

  assign res.valid = out_valid_q;
  assign res.data  = out_data_q;

  always_comb begin
    state_d      = state_q;
    rec_d        = rec_q;
    band_sum_d   = band_sum_q;
    band_cnt_d   = band_cnt_q;
    found_d      = found_q;
    line_d       = line_q;
    out_valid_d  = out_valid_q && !res.ready;
    out_data_d   = out_data_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    pop_o        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop_o = 1'b1;
          rec_d = fifo_data_i;
          if (fifo_data_i.cnt != '0) begin
            div_start    = 1'b1;
            div_dividend = fifo_data_i.sum;
            div_divisor  = fifo_data_i.cnt;
            state_d      = S_ROW_DIV;
          end else begin
            state_d = S_ROW_ADD;
          end
        end
      end
      S_ROW_DIV: begin
        if (div_done) begin
          state_d = S_ROW_ADD;
        end
      end
      S_ROW_ADD: begin
        band_sum_d = nxt_sum;
        band_cnt_d = nxt_cnt;
        if (rec_q.band_last) begin
          band_sum_d = '0;
          band_cnt_d = '0;
          if (nxt_cnt != '0) begin
            div_start    = 1'b1;
            div_dividend = bmc_pkg::RowSumW'(nxt_sum);
            div_divisor  = bmc_pkg::RowCntW'(nxt_cnt);
            state_d      = S_BAND_DIV;
          end else begin
            found_d = 1'b0;
            line_d  = '0;
            state_d = S_EMIT;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BAND_DIV: begin
        if (div_done) begin
          found_d = 1'b1;
          line_d  = div_quo[bmc_pkg::ColW-1:0];
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || res.ready) begin
          out_valid_d       = 1'b1;
          out_data_d.found  = found_q;
          out_data_d.line_x = line_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rec_q       <= '0;
      band_sum_q  <= '0;
      band_cnt_q  <= '0;
      found_q     <= 1'b0;
      line_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      rec_q       <= rec_d;
      band_sum_q  <= band_sum_d;
      band_cnt_q  <= band_cnt_d;
      found_q     <= found_d;
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  a_band_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_cnt_q <= bmc_pkg::BandCntCap)
    else $error("band row count above its cap");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_ROW_DIV || state_q == S_BAND_DIV))
    else $error("divider finished outside a divide state");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result raised without passing the emit state");

  a_band_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW_ADD && rec_q.band_last) |=> (band_cnt_q == '0 && band_sum_q == '0))
    else $error("band sums not cleared at band end");

endmodule

`default_nettype wire

[sv/band_mask_centroid_core.sv]
// Top level of the band mask centroid block: front part, row queue and back
// part. Depends on bmc_pkg, bmc_stream_if, bmc_front, bmc_fifo and bmc_back.
//
// Use: mask pixels enter on the pix channel (pixel_on, column, row_last,
// band_last), one transfer per pixel. Each band yields one transfer on the res
// channel (found, line_x) after the pixel that carries band_last. The cfg
// channel writes window_start (index 0) and window_end (index 1) and is always
// ready; write it only while the block is idle.
// Throughput: the front part takes one pixel per cycle while the four-entry
// row queue has room. The back part takes one row at a time: a row with set
// pixels in the window takes one pop, 17 divider steps, a check that the
// divider has finished and one add, any other row one pop and one add, so
// short rows fill the queue and pix.ready drops.
// After the band_last transfer the result goes through the row divide, the
// band divide on the same divider and the output register. Reset clears the
// row and band sums, the queue and the window registers to 0 and 512. A
// stalled receiver holds the result in the output register; the back part
// stops at the next band end and the front part once the queue fills.
`default_nettype none

module band_mask_centroid_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bmc_stream_if.sink   pix,
  bmc_stream_if.sink   cfg,
  bmc_stream_if.source res
);

  logic                push, pop;
  bmc_pkg::row_rec_t   push_data, pop_data;
  bmc_pkg::fifo_stat_t fifo_stat;

  bmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix         (pix),
    .cfg         (cfg),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bmc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  bmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .fifo_data_i (pop_data),
    .pop_o       (pop),
    .res         (res)
  );

endmodule

`default_nettype wire
